// ===== src/owtr_pkg.sv =====
// shared types, codes and sequencing helpers for the one-wire temperature reader
package owtr_pkg;

  // bus phases, one-hot
  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_RST_LOW  = 11'b000_0000_0010,
    PH_RST_WAIT = 11'b000_0000_0100,
    PH_RST_TAIL = 11'b000_0000_1000,
    PH_W_START  = 11'b000_0001_0000,
    PH_W_HOLD   = 11'b000_0010_0000,
    PH_W_REC    = 11'b000_0100_0000,
    PH_BYTE_REC = 11'b000_1000_0000,
    PH_R_START  = 11'b001_0000_0000,
    PH_R_WAIT   = 11'b010_0000_0000,
    PH_R_GAP    = 11'b100_0000_0000
  } phase_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_WRITE_SLOT    = 3'd3,
    CFG_READ_SAMPLE   = 3'd4,
    CFG_READ_GAP      = 3'd5,
    CFG_BYTE_RECOVERY = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 10;

  // sequence steps
  localparam logic [3:0] STEP_RESET_CONV  = 4'd0;
  localparam logic [3:0] STEP_SKIP_CONV   = 4'd1;
  localparam logic [3:0] STEP_CONVERT     = 4'd2;
  localparam logic [3:0] STEP_POLL        = 4'd3;
  localparam logic [3:0] STEP_RESET_READ  = 4'd4;
  localparam logic [3:0] STEP_SKIP_READ   = 4'd5;
  localparam logic [3:0] STEP_READ_CMD    = 4'd6;
  localparam logic [3:0] STEP_READ_LSB    = 4'd7;
  localparam logic [3:0] STEP_READ_MSB    = 4'd8;

  // sensor command bytes
  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;
  localparam logic [7:0] BYTE_ALL_ONES    = 8'hFF;

  // register reset values
  localparam logic [9:0] RST_RESET_LOW     = 10'd478;
  localparam logic [7:0] RST_PRESENCE_WAIT = 8'd54;
  localparam logic [9:0] RST_RESET_TAIL    = 10'd423;
  localparam logic [7:0] RST_WRITE_SLOT    = 8'd58;
  localparam logic [5:0] RST_READ_SAMPLE   = 6'd10;
  localparam logic [7:0] RST_READ_GAP      = 8'd45;
  localparam logic [7:0] RST_BYTE_RECOVERY = 8'd98;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_wait_us;
    logic [9:0] reset_tail_us;
    logic [7:0] write_slot_us;
    logic [5:0] read_sample_us;
    logic [7:0] read_gap_us;
    logic [7:0] byte_recovery_us;
  } cfg_t;

  // sequencer state apart from the microsecond counter
  typedef struct packed {
    phase_e      phase;
    logic [2:0]  bit_idx;
    logic [7:0]  shift_byte;
    logic [3:0]  seq_step;
    logic [7:0]  low_byte;
    logic [15:0] temp_word;
    logic        presence;
  } state_t;

  // one result beat
  typedef struct packed {
    logic        presence_seen;
    logic [15:0] temperature;
    logic        done_res;
    logic        busy_res;
    logic        drive_low;
  } res_t;

  typedef struct packed {
    logic [3:0] seq_step;
    logic [7:0] shift_byte;
    phase_e     phase;
  } step_entry_t;

  // entry into a sequence step: byte to send and first phase
  function automatic step_entry_t begin_step(logic [3:0] s, logic [7:0] cur_shift);
    step_entry_t e;
    e.seq_step   = s;
    e.shift_byte = 8'h00;
    e.phase      = PH_IDLE;
    case (s)
      STEP_RESET_CONV, STEP_RESET_READ: begin
        e.phase = PH_RST_LOW;
      end
      STEP_SKIP_CONV, STEP_SKIP_READ: begin
        e.shift_byte = CMD_SKIP_ROM;
        e.phase      = PH_W_START;
      end
      STEP_CONVERT: begin
        e.shift_byte = CMD_CONVERT;
        e.phase      = PH_W_START;
      end
      STEP_READ_CMD: begin
        e.shift_byte = CMD_READ_SCRATCH;
        e.phase      = PH_W_START;
      end
      STEP_POLL, STEP_READ_LSB, STEP_READ_MSB: begin
        e.phase = PH_R_START;
      end
      default: begin
        // step outside the sequence: back to idle, byte kept
        e.seq_step   = STEP_RESET_CONV;
        e.shift_byte = cur_shift;
        e.phase      = PH_IDLE;
      end
    endcase
    return e;
  endfunction

endpackage

// ===== src/owtr_cfg_regs.sv =====
// timing register bank written through the plain configuration port
module owtr_cfg_regs
  import owtr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RESET_LOW:     cfg_d.reset_low_us     = cfg_data_i[9:0];
        CFG_PRESENCE_WAIT: cfg_d.presence_wait_us = cfg_data_i[7:0];
        CFG_RESET_TAIL:    cfg_d.reset_tail_us    = cfg_data_i[9:0];
        CFG_WRITE_SLOT:    cfg_d.write_slot_us    = cfg_data_i[7:0];
        CFG_READ_SAMPLE:   cfg_d.read_sample_us   = cfg_data_i[5:0];
        CFG_READ_GAP:      cfg_d.read_gap_us      = cfg_data_i[7:0];
        CFG_BYTE_RECOVERY: cfg_d.byte_recovery_us = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us     <= RST_RESET_LOW;
      cfg_q.presence_wait_us <= RST_PRESENCE_WAIT;
      cfg_q.reset_tail_us    <= RST_RESET_TAIL;
      cfg_q.write_slot_us    <= RST_WRITE_SLOT;
      cfg_q.read_sample_us   <= RST_READ_SAMPLE;
      cfg_q.read_gap_us      <= RST_READ_GAP;
      cfg_q.byte_recovery_us <= RST_BYTE_RECOVERY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/owtr_step.sv =====
// next-state and result logic for one microsecond tick of the bus sequencer
module owtr_step
  import owtr_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 10
) (
  input  cfg_t                    cfg_i,
  input  state_t                  st_i,
  input  logic [COUNTER_BITS-1:0] cnt_i,
  input  logic                    op_i,
  input  logic                    line_i,
  output state_t                  st_o,
  output logic [COUNTER_BITS-1:0] cnt_o,
  output res_t                    res_o
);

  localparam int unsigned LimW = (COUNTER_BITS + 1 > 10) ? COUNTER_BITS + 1 : 10;
  localparam logic [LimW-1:0] CntTop = LimW'(1) << COUNTER_BITS;

  always_comb begin
    state_t                  cur;
    state_t                  nxt;
    logic [COUNTER_BITS-1:0] cnt;
    logic [COUNTER_BITS-1:0] cnt_n;
    logic [9:0]              dur;
    logic [LimW-1:0]         lim;
    logic [LimW-1:0]         inc;
    logic                    last;
    logic                    drive;
    logic                    done;
    logic                    do_begin;
    logic [3:0]              begin_arg;
    step_entry_t             be;

    cur       = st_i;
    cnt       = cnt_i;
    drive     = 1'b0;
    done      = 1'b0;
    dur       = 10'd1;
    do_begin  = 1'b0;
    begin_arg = STEP_RESET_CONV;

    // start request only taken while idle
    if (cur.phase == PH_IDLE && op_i) begin
      be             = begin_step(STEP_RESET_CONV, cur.shift_byte);
      cur.seq_step   = be.seq_step;
      cur.shift_byte = be.shift_byte;
      cur.phase      = be.phase;
      cur.bit_idx    = 3'd0;
      cnt            = '0;
    end

    // drive level, duration and line sampling of the current phase
    case (cur.phase)
      PH_RST_LOW: begin
        drive = 1'b1;
        dur   = cfg_i.reset_low_us;
      end
      PH_RST_WAIT: dur = 10'(cfg_i.presence_wait_us);
      PH_RST_TAIL: begin
        dur = cfg_i.reset_tail_us;
        if (cnt == '0) cur.presence = ~line_i;
      end
      PH_W_START:  drive = 1'b1;
      PH_W_HOLD: begin
        drive = ~cur.shift_byte[0];
        dur   = 10'(cfg_i.write_slot_us);
      end
      PH_W_REC:    dur = 10'd2;
      PH_BYTE_REC: dur = 10'(cfg_i.byte_recovery_us);
      PH_R_START:  drive = 1'b1;
      PH_R_WAIT:   dur = 10'(cfg_i.read_sample_us);
      PH_R_GAP: begin
        dur = 10'(cfg_i.read_gap_us);
        if (cnt == '0) cur.shift_byte[cur.bit_idx] = cur.shift_byte[cur.bit_idx] | line_i;
      end
      default: ;
    endcase

    // clamp the duration to one tick at least and the counter span at most
    lim = (dur == 10'd0) ? LimW'(1) : LimW'(dur);
    if (lim > CntTop) lim = CntTop;
    inc  = LimW'(cnt) + LimW'(1);
    last = (inc >= lim);

    nxt   = cur;
    cnt_n = cnt;

    // phase transitions
    if (cur.phase != PH_IDLE) begin
      if (!last) begin
        cnt_n = cnt + COUNTER_BITS'(1);
      end else begin
        cnt_n = '0;
        case (cur.phase)
          PH_RST_LOW:  nxt.phase = PH_RST_WAIT;
          PH_RST_WAIT: nxt.phase = PH_RST_TAIL;
          PH_RST_TAIL: begin
            do_begin  = 1'b1;
            begin_arg = cur.seq_step + 4'd1;
          end
          PH_W_START:  nxt.phase = PH_W_HOLD;
          PH_W_HOLD:   nxt.phase = PH_W_REC;
          PH_W_REC: begin
            if (cur.bit_idx == 3'd7) begin
              nxt.phase = PH_BYTE_REC;
            end else begin
              nxt.bit_idx    = cur.bit_idx + 3'd1;
              nxt.shift_byte = cur.shift_byte >> 1;
              nxt.phase      = PH_W_START;
            end
          end
          PH_BYTE_REC: begin
            do_begin  = 1'b1;
            begin_arg = cur.seq_step + 4'd1;
          end
          PH_R_START:  nxt.phase = PH_R_WAIT;
          PH_R_WAIT:   nxt.phase = PH_R_GAP;
          PH_R_GAP: begin
            if (cur.bit_idx == 3'd7) begin
              // whole byte read
              case (cur.seq_step)
                STEP_POLL: begin
                  do_begin  = 1'b1;
                  begin_arg = (cur.shift_byte == BYTE_ALL_ONES) ? STEP_POLL
                                                                 : STEP_RESET_READ;
                end
                STEP_READ_LSB: begin
                  nxt.low_byte = cur.shift_byte;
                  do_begin     = 1'b1;
                  begin_arg    = STEP_READ_MSB;
                end
                STEP_READ_MSB: begin
                  nxt.temp_word = {cur.shift_byte, cur.low_byte};
                  nxt.seq_step  = STEP_RESET_CONV;
                  nxt.phase     = PH_IDLE;
                  done          = 1'b1;
                end
                default: begin
                  nxt.seq_step = STEP_RESET_CONV;
                  nxt.phase    = PH_IDLE;
                end
              endcase
            end else begin
              nxt.bit_idx = cur.bit_idx + 3'd1;
              nxt.phase   = PH_R_START;
            end
          end
          default: begin
            nxt.seq_step = STEP_RESET_CONV;
            nxt.phase    = PH_IDLE;
          end
        endcase
      end
    end

    // enter the next sequence step
    be = begin_step(begin_arg, cur.shift_byte);
    if (do_begin) begin
      nxt.seq_step   = be.seq_step;
      nxt.shift_byte = be.shift_byte;
      nxt.phase      = be.phase;
      nxt.bit_idx    = 3'd0;
    end

    st_o  = nxt;
    cnt_o = cnt_n;

    res_o.drive_low     = drive;
    res_o.busy_res      = (nxt.phase != PH_IDLE);
    res_o.done_res      = done;
    res_o.temperature   = nxt.temp_word;
    res_o.presence_seen = nxt.presence;
  end

endmodule

// ===== src/one_wire_temperature_reader.sv =====
// top level of the one-wire temperature reader: state, result register and handshakes

// One-wire bus master that reads a temperature sensor. Every input beat is one
// microsecond tick carrying the sampled bus level in tdata bit 0 and a start
// request in tuser; every input beat yields exactly one output beat with the
// drive level for that tick, busy and done flags, the last raw temperature word
// and the presence flag. The state is updated once per accepted tick, so a tick
// is taken every cycle unless m_axis_tready stalls the output: the step logic
// between state and result registers sets that rate, and the result register lets
// a new tick in while the previous beat is taken. Timing registers are to be
// written through the configuration port while no tick is pending; not enforced.
module one_wire_temperature_reader
  import owtr_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input ticks
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [0] line_level, [7:1] zero
  input  logic                s_axis_tuser,   // [0] operation
  // result beats
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata    // [0] drive_low, [1] busy_res,
                                              // [2] done_res, [18:3] temperature,
                                              // [19] presence_seen, [23:20] zero
);

  cfg_t                    cfg;
  state_t                  st_q, st_d;
  logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
  res_t                    res_d, res_q;
  logic                    m_valid_q;
  logic                    s_accept;

  owtr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  owtr_step #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .cnt_i  (cnt_q),
    .op_i   (s_axis_tuser),
    .line_i (s_axis_tdata[0]),
    .st_o   (st_d),
    .cnt_o  (cnt_d),
    .res_o  (res_d)
  );

  // take a tick whenever the result register is free or being emptied
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_IDLE;
      st_q.bit_idx    <= 3'd0;
      st_q.shift_byte <= 8'h00;
      st_q.seq_step   <= STEP_RESET_CONV;
      st_q.low_byte   <= 8'h00;
      st_q.temp_word  <= 16'h0000;
      st_q.presence   <= 1'b0;
      cnt_q           <= '0;
    end else if (s_accept) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.presence_seen, res_q.temperature,
                          res_q.done_res, res_q.busy_res, res_q.drive_low};

  // a done beat never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && res_d.done_res |-> !res_d.busy_res)
    else $error("done beat reports busy");

  // the sequencer returns to idle after a done beat
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && res_d.done_res |=> st_q.phase == PH_IDLE)
    else $error("sequencer not idle after done");

  // the tick counter is clear whenever idle
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_IDLE |-> cnt_q == '0)
    else $error("tick counter running while idle");

  // an accepted tick always leaves a result beat pending
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_valid_q)
    else $error("accepted tick without result beat");

endmodule
